FILE: hdl/msp_pkg.sv
package msp_pkg;

    // Number of motor loops held in the state memory.
    localparam int NUM_MOTORS = 4;

    // Field widths of the tick and result channels.
    localparam int IDX_W   = 2;
    localparam int SPEED_W = 16;
    localparam int DRIVE_W = 16;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    // Register field widths.
    localparam int GAIN_W   = 20;
    localparam int ILIM_W   = 20;
    localparam int DLIM_W   = 15;
    localparam int WEIGHT_W = 9;
    localparam int THR_W    = 16;

    // Per-motor state widths.
    localparam int INTEG_W  = 22;
    localparam int ERR_W    = 17;
    localparam int SMOOTH_W = 25;

    // Errors below this magnitude leave the loop untouched.
    localparam logic [ERR_W-1:0] DEAD_BAND = 17'd3;

    // 1.0 in Q1.8.
    localparam logic [WEIGHT_W-1:0] ONE_Q8 = 9'd256;

    // Register reset values.
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST    = 20'sd81920;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST   = 20'sd410;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST   = 20'sd25600;
    localparam logic signed [GAIN_W-1:0] FEEDFWD_GAIN_RST = 20'sd0;
    localparam logic [ILIM_W-1:0]        INTEG_LIMIT_RST  = 20'd1000;
    localparam logic [DLIM_W-1:0]        DRIVE_LIMIT_RST  = 15'd8000;
    localparam logic [WEIGHT_W-1:0]      SMOOTH_W_RST     = 9'd166;
    localparam logic [THR_W-1:0]         SEP_THR_RST      = 16'd15;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INTEG_GAIN   = 3'd1,
        CFG_DERIV_GAIN   = 3'd2,
        CFG_FEEDFWD_GAIN = 3'd3,
        CFG_INTEG_LIMIT  = 3'd4,
        CFG_DRIVE_LIMIT  = 3'd5,
        CFG_SMOOTH_WEIGHT = 3'd6,
        CFG_SEP_THRESHOLD = 3'd7
    } cfg_index_t;

    // One word of the state memory per motor.
    typedef struct packed {
        logic signed [INTEG_W-1:0]  integral_sum;
        logic signed [ERR_W-1:0]    last_error;
        logic signed [SPEED_W-1:0]  last_target;
        logic signed [SMOOTH_W-1:0] smoothed_drive;
    } loop_state_t;

    localparam int STATE_W = $bits(loop_state_t);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_F,
        ST_MUL_I,
        ST_CLAMP,
        ST_SMOOTH,
        ST_FINAL,
        ST_DONE
    } msp_state_t;

endpackage

FILE: hdl/msp_in_if.sv
interface msp_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [msp_pkg::IDX_W-1:0]                 motor_index;
    logic signed [msp_pkg::SPEED_W-1:0]        target_speed;
    logic signed [msp_pkg::SPEED_W-1:0]        measured_speed;

    modport source (output valid, output motor_index, output target_speed,
                    output measured_speed, input ready);
    modport sink (input valid, input motor_index, input target_speed,
                  input measured_speed, output ready);
endinterface

FILE: hdl/msp_out_if.sv
interface msp_out_if;
    logic                               valid;
    logic                               ready;
    logic [msp_pkg::IDX_W-1:0]          motor_echo;
    logic signed [msp_pkg::DRIVE_W-1:0] drive_value;

    modport source (output valid, output motor_echo, output drive_value, input ready);
    modport sink (input valid, input motor_echo, input drive_value, output ready);
endinterface

FILE: hdl/motor_speed_pid_step.sv
// Per-motor PID speed controller with feedforward, integral separation and
// output smoothing. Each request names a motor and carries its target and
// measured speed; exactly one result (motor echo and int16 drive) comes back
// per request, in order. Loop state for all motors sits in one synchronous
// memory; it is read per request and, for a request that leads to a control
// update, updated and written back. The block works on one request at a
// time. An updating request steps through the memory read, five passes
// through the single shared 26x20 multiplier, the clamp step, the final
// smoothing step and the load of the result register; a request inside the
// dead band, or for a motor index beyond the configured count, goes from
// the memory read straight to the load of the result register. The next
// request is taken in the cycle after a result is loaded. A result not yet
// taken holds the block in its last step, since only one result can wait in
// the result register. Memory contents are marked by per-motor valid bits
// cleared at reset, so no clearing pass is needed after reset.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce it.
module motor_speed_pid_step #(
    parameter int NUM_MOTORS = msp_pkg::NUM_MOTORS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    msp_in_if.sink                              tick,
    msp_out_if.source                           drive,
    input  logic                                cfg_we,
    input  logic [msp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int ADDR_W = NUM_MOTORS > 1 ? $clog2(NUM_MOTORS) : 1;

    // Configuration registers.
    logic signed [msp_pkg::GAIN_W-1:0]  prop_gain_reg;
    logic signed [msp_pkg::GAIN_W-1:0]  integ_gain_reg;
    logic signed [msp_pkg::GAIN_W-1:0]  deriv_gain_reg;
    logic signed [msp_pkg::GAIN_W-1:0]  feedfwd_gain_reg;
    logic [msp_pkg::ILIM_W-1:0]         integ_limit_reg;
    logic [msp_pkg::DLIM_W-1:0]         drive_limit_reg;
    logic [msp_pkg::WEIGHT_W-1:0]       smooth_weight_reg;
    logic [msp_pkg::THR_W-1:0]          sep_thr_reg;

    // Sequencer.
    msp_pkg::msp_state_t state_reg;
    msp_pkg::msp_state_t state_next;

    // Control strobes.
    logic accept;
    logic load_out;
    logic ram_we;
    logic ram_re;

    // Request and loop state held for the current request.
    logic [msp_pkg::IDX_W-1:0]          idx_reg;
    logic                               in_range_reg;
    logic                               stored_valid_reg;
    logic signed [msp_pkg::SPEED_W-1:0] tgt_reg;
    logic signed [msp_pkg::ERR_W-1:0]   err_reg;
    logic signed [msp_pkg::INTEG_W-1:0] int_reg;
    logic signed [msp_pkg::ERR_W-1:0]   le_reg;
    logic signed [msp_pkg::SPEED_W-1:0] lt_reg;
    logic signed [msp_pkg::SMOOTH_W-1:0] s_old_reg;
    logic                               sep_reg;
    logic                               update_reg;

    // Arithmetic registers.
    logic signed [45:0]                  prod_reg;
    logic signed [43:0]                  acc_reg;
    logic signed [msp_pkg::SMOOTH_W-1:0] raw_reg;
    logic signed [msp_pkg::INTEG_W-1:0]  int_new_reg;
    logic signed [msp_pkg::SMOOTH_W-1:0] s_new_reg;

    // Result register.
    logic                               out_valid_reg;
    logic [msp_pkg::IDX_W-1:0]          out_motor_reg;
    logic signed [msp_pkg::DRIVE_W-1:0] out_drive_reg;

    // Memory and valid bits.
    logic [NUM_MOTORS-1:0]   valid_reg;
    logic [ADDR_W-1:0]       raddr;
    logic [ADDR_W-1:0]       waddr;
    logic [msp_pkg::STATE_W-1:0] ram_rdata;
    msp_pkg::loop_state_t    rd_word;
    msp_pkg::loop_state_t    wr_word;
    logic                    tick_in_range;

    // Combinational datapath signals.
    logic [msp_pkg::ERR_W-1:0]           aerr;
    logic                                dead;
    logic signed [25:0]                  mul_a;
    logic signed [msp_pkg::GAIN_W-1:0]   mul_b;
    logic [msp_pkg::WEIGHT_W-1:0]        w_sat;
    logic signed [43:0]                  raw_sum;
    logic signed [43:0]                  lim_s;
    logic signed [22:0]                  int_sum;
    logic signed [22:0]                  ilim_s;
    logic signed [35:0]                  smooth_sum;
    logic signed [16:0]                  drive_q;
    logic                                drive_round;
    logic signed [msp_pkg::DRIVE_W-1:0]  drive_calc;

    // Configuration writes; unknown indexes cannot occur with a 3-bit index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= msp_pkg::PROP_GAIN_RST;
            integ_gain_reg    <= msp_pkg::INTEG_GAIN_RST;
            deriv_gain_reg    <= msp_pkg::DERIV_GAIN_RST;
            feedfwd_gain_reg  <= msp_pkg::FEEDFWD_GAIN_RST;
            integ_limit_reg   <= msp_pkg::INTEG_LIMIT_RST;
            drive_limit_reg   <= msp_pkg::DRIVE_LIMIT_RST;
            smooth_weight_reg <= msp_pkg::SMOOTH_W_RST;
            sep_thr_reg       <= msp_pkg::SEP_THR_RST;
        end
        else if (cfg_we)
        begin
            case (msp_pkg::cfg_index_t'(cfg_index))
                msp_pkg::CFG_PROP_GAIN:     prop_gain_reg     <= $signed(cfg_data);
                msp_pkg::CFG_INTEG_GAIN:    integ_gain_reg    <= $signed(cfg_data);
                msp_pkg::CFG_DERIV_GAIN:    deriv_gain_reg    <= $signed(cfg_data);
                msp_pkg::CFG_FEEDFWD_GAIN:  feedfwd_gain_reg  <= $signed(cfg_data);
                msp_pkg::CFG_INTEG_LIMIT:   integ_limit_reg   <= cfg_data;
                msp_pkg::CFG_DRIVE_LIMIT:   drive_limit_reg   <= cfg_data[msp_pkg::DLIM_W-1:0];
                msp_pkg::CFG_SMOOTH_WEIGHT: smooth_weight_reg <= cfg_data[msp_pkg::WEIGHT_W-1:0];
                msp_pkg::CFG_SEP_THRESHOLD: sep_thr_reg       <= cfg_data[msp_pkg::THR_W-1:0];
                default:                    prop_gain_reg     <= prop_gain_reg;
            endcase
        end
    end

    // State memory.
    assign raddr = ADDR_W'(tick.motor_index);
    assign waddr = ADDR_W'(idx_reg);
    assign tick_in_range = 32'(tick.motor_index) < 32'(NUM_MOTORS);
    assign rd_word = stored_valid_reg ? msp_pkg::loop_state_t'(ram_rdata)
                                      : msp_pkg::loop_state_t'('0);

    assign wr_word.integral_sum   = int_new_reg;
    assign wr_word.last_error     = err_reg;
    assign wr_word.last_target    = tgt_reg;
    assign wr_word.smoothed_drive = s_new_reg;

    msp_ram #(
        .WIDTH(msp_pkg::STATE_W),
        .DEPTH(NUM_MOTORS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wr_word),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Valid bits stand in for the zero reset of the memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msp_pkg::ST_IDLE:
            begin
                if (tick.valid)
                begin
                    state_next = msp_pkg::ST_LOAD;
                end
            end
            msp_pkg::ST_LOAD:
            begin
                if (!in_range_reg || dead)
                begin
                    state_next = msp_pkg::ST_DONE;
                end
                else
                begin
                    state_next = msp_pkg::ST_MUL_P;
                end
            end
            msp_pkg::ST_MUL_P:  state_next = msp_pkg::ST_MUL_D;
            msp_pkg::ST_MUL_D:  state_next = msp_pkg::ST_MUL_F;
            msp_pkg::ST_MUL_F:  state_next = msp_pkg::ST_MUL_I;
            msp_pkg::ST_MUL_I:  state_next = msp_pkg::ST_CLAMP;
            msp_pkg::ST_CLAMP:  state_next = msp_pkg::ST_SMOOTH;
            msp_pkg::ST_SMOOTH: state_next = msp_pkg::ST_FINAL;
            msp_pkg::ST_FINAL:  state_next = msp_pkg::ST_DONE;
            msp_pkg::ST_DONE:
            begin
                if (!out_valid_reg || drive.ready)
                begin
                    state_next = msp_pkg::ST_IDLE;
                end
            end
            default:            state_next = msp_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        tick.ready = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            msp_pkg::ST_IDLE: tick.ready = 1'b1;
            msp_pkg::ST_DONE: load_out   = !out_valid_reg || drive.ready;
            default:
            begin
                tick.ready = 1'b0;
                load_out   = 1'b0;
            end
        endcase
    end

    assign accept = tick.valid && tick.ready;
    assign ram_re = accept;
    assign ram_we = load_out && update_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Error magnitude, dead band and integral separation.
    assign aerr = err_reg[msp_pkg::ERR_W-1] ? msp_pkg::ERR_W'(-err_reg)
                                            : msp_pkg::ERR_W'(err_reg);
    assign dead = aerr < msp_pkg::DEAD_BAND;

    assign w_sat = (smooth_weight_reg > msp_pkg::ONE_Q8) ? msp_pkg::ONE_Q8
                                                         : smooth_weight_reg;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            msp_pkg::ST_MUL_P:
            begin
                mul_a = 26'(err_reg);
                mul_b = prop_gain_reg;
            end
            msp_pkg::ST_MUL_D:
            begin
                mul_a = 26'(err_reg) - 26'(le_reg);
                mul_b = deriv_gain_reg;
            end
            msp_pkg::ST_MUL_F:
            begin
                mul_a = 26'(tgt_reg) - 26'(lt_reg);
                mul_b = feedfwd_gain_reg;
            end
            msp_pkg::ST_MUL_I:
            begin
                mul_a = 26'(int_reg);
                mul_b = sep_reg ? integ_gain_reg : '0;
            end
            msp_pkg::ST_SMOOTH:
            begin
                mul_a = 26'(s_old_reg) - 26'(raw_reg);
                mul_b = $signed({11'b0, w_sat});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Final sum, output clamp and integral clamp.
    assign raw_sum = acc_reg + 44'(prod_reg);
    assign lim_s   = $signed({21'b0, drive_limit_reg, 8'b0});
    assign int_sum = 23'(int_reg) + 23'(err_reg);
    assign ilim_s  = $signed({3'b0, integ_limit_reg});

    // Smoothing: w*s + (1-w)*raw written as w*(s-raw) + raw, floored.
    assign smooth_sum = 36'(prod_reg) + (36'(raw_reg) <<< 8);

    // Drive is the smoothed value truncated toward zero.
    assign drive_q     = s_new_reg[msp_pkg::SMOOTH_W-1:8];
    assign drive_round = s_new_reg[msp_pkg::SMOOTH_W-1] && (s_new_reg[7:0] != 8'd0);
    assign drive_calc  = in_range_reg ? msp_pkg::DRIVE_W'(drive_q + 17'(drive_round))
                                      : '0;

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            msp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    idx_reg          <= tick.motor_index;
                    in_range_reg     <= tick_in_range;
                    stored_valid_reg <= tick_in_range && valid_reg[raddr];
                    tgt_reg          <= tick.target_speed;
                    err_reg          <= 17'(tick.target_speed) - 17'(tick.measured_speed);
                end
            end
            msp_pkg::ST_LOAD:
            begin
                int_reg     <= rd_word.integral_sum;
                int_new_reg <= rd_word.integral_sum;
                le_reg      <= rd_word.last_error;
                lt_reg      <= rd_word.last_target;
                s_old_reg   <= rd_word.smoothed_drive;
                s_new_reg   <= rd_word.smoothed_drive;
                sep_reg     <= aerr <= 17'(sep_thr_reg);
                update_reg  <= in_range_reg && !dead;
            end
            msp_pkg::ST_MUL_D:
            begin
                acc_reg <= 44'(prod_reg);
            end
            msp_pkg::ST_MUL_F, msp_pkg::ST_MUL_I:
            begin
                acc_reg <= acc_reg + 44'(prod_reg);
            end
            msp_pkg::ST_CLAMP:
            begin
                if (raw_sum > lim_s)
                begin
                    raw_reg <= 25'(lim_s);
                end
                else if (raw_sum < -lim_s)
                begin
                    raw_reg <= 25'(-lim_s);
                end
                else
                begin
                    raw_reg <= 25'(raw_sum);
                end
                if (sep_reg)
                begin
                    if (int_sum > ilim_s)
                    begin
                        int_new_reg <= 22'(ilim_s);
                    end
                    else if (int_sum < -ilim_s)
                    begin
                        int_new_reg <= 22'(-ilim_s);
                    end
                    else
                    begin
                        int_new_reg <= 22'(int_sum);
                    end
                end
            end
            msp_pkg::ST_FINAL:
            begin
                s_new_reg <= 25'(smooth_sum >>> 8);
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // Result register; it holds until the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (drive.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_motor_reg <= idx_reg;
            out_drive_reg <= drive_calc;
        end
    end

    assign drive.valid       = out_valid_reg;
    assign drive.motor_echo  = out_motor_reg;
    assign drive.drive_value = out_drive_reg;

`ifndef NO_ASSERTIONS
    // An accepted request always moves on to the memory read step.
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == msp_pkg::ST_LOAD)
        else $error("accepted request did not reach the load step");

    // State is written back only in the result step, for a motor in range.
    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == msp_pkg::ST_DONE) && in_range_reg)
        else $error("state write outside the result step");

    // A new result appears only from the result step.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == msp_pkg::ST_DONE))
        else $error("result raised outside the result step");

    // A written integral that was updated lies within the configured limit.
    a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && sep_reg) |->
            (int_new_reg <= $signed({2'b0, integ_limit_reg})) &&
            (int_new_reg >= -$signed({2'b0, integ_limit_reg})))
        else $error("integral written beyond its limit");

    // No request is taken while a previous one is still being worked on.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != msp_pkg::ST_IDLE) |-> !tick.ready)
        else $error("request accepted while busy");
`endif

endmodule

FILE: hdl/msp_ram.sv
module msp_ram #(
    parameter int WIDTH = msp_pkg::STATE_W,
    parameter int DEPTH = msp_pkg::NUM_MOTORS
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
